FILE: rtl/radar_frame_to_modbus_bridge_assert.svh
// Assertion macros for the radar frame to Modbus bridge.
// Included by the top level; relies on i_clk and i_rst_n in the including scope.
`ifndef RADAR_FRAME_TO_MODBUS_BRIDGE_ASSERT_SVH
`define RADAR_FRAME_TO_MODBUS_BRIDGE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define RF2MB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rf2mb: same-cycle check failed");
// next-cycle implication
`define RF2MB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rf2mb: next-cycle check failed");
`else
`define RF2MB_ASSERT_NOW(lbl, ante, cons)
`define RF2MB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/rf2mb_pkg.sv
// Shared types, constants and CRC helper for the radar frame to Modbus bridge.
// No dependencies.
package rf2mb_pkg;

    localparam int HDR_LEN    = 8;
    localparam int TAG_LEN    = 4;
    localparam int HEAD_BYTES = 6;
    localparam int PREFIX_LEN = 7;
    localparam int FRAME_LEN  = 15;
    localparam int IDX_W      = 4;   // frame byte index 0..14
    localparam int HPOS_W     = 4;   // header position 0..8
    localparam int CNT_W      = 3;   // captured payload bytes 0..6
    localparam int QDEPTH     = 2;   // power of two
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [7:0] FRAME_PREFIX [PREFIX_LEN] =
        '{8'h01, 8'h10, 8'h00, 8'h00, 8'h00, 8'h03, 8'h06};
    localparam logic [7:0] TAG_PDAT [TAG_LEN] = '{8'h50, 8'h44, 8'h41, 8'h54};

    typedef struct packed {
        logic [8*HEAD_BYTES-1:0] head;
        logic [15:0]             crc;
    } t_frame;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic             busy;
        logic [IDX_W-1:0] idx;
    } t_back_stat;

    // CRC-16/Modbus, one byte, reflected
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic [15:0] prefix_crc();
        logic [15:0] c;
        c = CRC_INIT;
        for (int i = 0; i < PREFIX_LEN; i++) begin
            c = crc_byte(c, FRAME_PREFIX[i]);
        end
        return c;
    endfunction

    localparam logic [15:0] PREFIX_CRC = prefix_crc();

endpackage

FILE: rtl/rf2mb_rx_if.sv
// Receive channel: valid/ready handshake carrying one radar byte.
// No dependencies.
interface rf2mb_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/rf2mb_tx_if.sv
// Transmit channel: valid/ready handshake carrying one Modbus frame byte.
// No dependencies.
interface rf2mb_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       frame_end;

    modport source (output valid, output tx_byte, output frame_end, input ready);
    modport sink   (input valid, input tx_byte, input frame_end, output ready);
endinterface

FILE: rtl/rf2mb_front.sv
// Packet parser: tracks header, tag match, length and first six payload bytes.
// Depends on rf2mb_pkg.
module rf2mb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_byte,
    output logic              o_push,
    output rf2mb_pkg::t_frame o_frame
);

    logic [rf2mb_pkg::HPOS_W-1:0] r_hpos, n_hpos;
    logic                         r_tag_ok, n_tag_ok;
    logic [31:0]                  r_len, n_len;     // length, then bytes remaining
    logic [rf2mb_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [47:0]                  r_head, n_head;
    logic [15:0]                  r_crc, n_crc;
    logic                         restart;

    always_comb begin
        n_hpos   = r_hpos;
        n_tag_ok = r_tag_ok;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_head   = r_head;
        n_crc    = r_crc;
        restart  = 1'b0;
        o_push   = 1'b0;
        if (i_take) begin
            if (r_hpos < rf2mb_pkg::HPOS_W'(rf2mb_pkg::TAG_LEN)) begin
                if (i_byte != rf2mb_pkg::TAG_PDAT[r_hpos[1:0]]) begin
                    n_tag_ok = 1'b0;
                end
                n_hpos = r_hpos + 1'b1;
            end else if (r_hpos < rf2mb_pkg::HPOS_W'(rf2mb_pkg::HDR_LEN)) begin
                n_len[{r_hpos[1:0], 3'b000} +: 8] = i_byte;
                n_hpos = r_hpos + 1'b1;
                // zero-length payload ends the packet here
                if (r_hpos == rf2mb_pkg::HPOS_W'(rf2mb_pkg::HDR_LEN - 1) &&
                    i_byte == 8'h00 && r_len[23:0] == 24'h0) begin
                    restart = 1'b1;
                end
            end else begin
                if (r_cnt < rf2mb_pkg::CNT_W'(rf2mb_pkg::HEAD_BYTES)) begin
                    n_head[{r_cnt, 3'b000} +: 8] = i_byte;
                    n_crc = rf2mb_pkg::crc_byte(r_crc, i_byte);
                    n_cnt = r_cnt + 1'b1;
                end
                n_len = r_len - 32'd1;
                if (r_len == 32'd1) begin
                    o_push  = r_tag_ok && (n_cnt == rf2mb_pkg::CNT_W'(rf2mb_pkg::HEAD_BYTES));
                    restart = 1'b1;
                end
            end
        end
        o_frame.head = n_head;
        o_frame.crc  = n_crc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_hpos   <= '0;
            r_tag_ok <= 1'b1;
            r_cnt    <= '0;
            r_crc    <= rf2mb_pkg::PREFIX_CRC;
        end else begin
            r_hpos   <= n_hpos;
            r_tag_ok <= n_tag_ok;
            r_cnt    <= n_cnt;
            r_crc    <= n_crc;
        end
        r_len  <= n_len;
        r_head <= n_head;
    end

endmodule

FILE: rtl/rf2mb_queue.sv
// Short frame queue between parser and serialiser.
// Depends on rf2mb_pkg.
module rf2mb_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rf2mb_pkg::t_frame i_frame,
    input  logic              i_pop,
    output rf2mb_pkg::t_frame o_frame,
    output rf2mb_pkg::t_q_stat o_stat
);

    rf2mb_pkg::t_frame            r_mem [rf2mb_pkg::QDEPTH];
    logic [rf2mb_pkg::QPTR_W-1:0] r_wp, r_rp;
    logic [rf2mb_pkg::QCNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        unique case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wp] <= i_frame;
        end
    end

    assign o_frame      = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == rf2mb_pkg::QCNT_W'(rf2mb_pkg::QDEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

FILE: rtl/rf2mb_serial.sv
// Frame serialiser: sends prefix, six payload bytes and CRC, one word a cycle while ready.
// Depends on rf2mb_pkg and rf2mb_tx_if.
module rf2mb_serial (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  rf2mb_pkg::t_frame     i_frame,
    output logic                  o_pop,
    output rf2mb_pkg::t_back_stat o_stat,
    rf2mb_tx_if.source            o_tx
);

    logic                        r_busy;
    logic [rf2mb_pkg::IDX_W-1:0] r_idx;
    logic [rf2mb_pkg::IDX_W-1:0] head_idx;
    rf2mb_pkg::t_frame           r_frame;
    logic                        fire;
    logic                        last;

    assign fire  = o_tx.valid && o_tx.ready;
    assign last  = (r_idx == rf2mb_pkg::IDX_W'(rf2mb_pkg::FRAME_LEN - 1));
    assign o_pop = i_q_valid && (!r_busy || (fire && last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (fire) begin
            if (last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
        if (o_pop) begin
            r_frame <= i_frame;
        end
    end

    assign head_idx = r_idx - rf2mb_pkg::IDX_W'(rf2mb_pkg::PREFIX_LEN);

    always_comb begin
        priority if (r_idx < rf2mb_pkg::IDX_W'(rf2mb_pkg::PREFIX_LEN)) begin
            o_tx.tx_byte = rf2mb_pkg::FRAME_PREFIX[r_idx[2:0]];
        end else if (r_idx < rf2mb_pkg::IDX_W'(rf2mb_pkg::PREFIX_LEN + rf2mb_pkg::HEAD_BYTES)) begin
            o_tx.tx_byte = r_frame.head[{head_idx[2:0], 3'b000} +: 8];
        end else if (!last) begin
            o_tx.tx_byte = r_frame.crc[7:0];
        end else begin
            o_tx.tx_byte = r_frame.crc[15:8];
        end
    end

    assign o_tx.valid     = r_busy;
    assign o_tx.frame_end = last;
    assign o_stat.busy    = r_busy;
    assign o_stat.idx     = r_idx;

endmodule

FILE: rtl/radar_frame_to_modbus_bridge.sv
// Radar packet stream to Modbus RTU write-multiple-registers bridge.
// Input side i_rx (sink): one radar byte per word; packets are a 4-byte tag,
//   a 32-bit little-endian length and the payload. No resync on bad streams.
// Output side o_tx (source): 15-word Modbus frames, 01 10 00 00 00 03 06,
//   the first six payload bytes, CRC-16/Modbus low byte first; frame_end
//   marks the last word. A frame goes out only for tag PDAT with payload >= 6.
// Throughput: one input word per cycle while the frame queue has room; one
//   output word per cycle while o_tx.ready is high.
// Path: the queue takes the frame on the edge that takes the last payload
//   byte; the serialiser then loads it, once idle, and raises o_tx.valid.
// Stall: if o_tx is held off, frames wait in the two-entry queue and the
//   parser keeps taking bytes; i_rx.ready drops only when the queue is full.
// Reset (i_rst_n low, synchronous): parser returns to start of packet, queue
//   empties and o_tx.valid falls.
// Depends on rf2mb_pkg, the two channel interfaces and the assertion header.
`include "radar_frame_to_modbus_bridge_assert.svh"

module radar_frame_to_modbus_bridge (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rf2mb_rx_if.sink    i_rx,
    rf2mb_tx_if.source  o_tx
);

    logic                  take;
    logic                  push;
    logic                  pop;
    rf2mb_pkg::t_frame     push_frame;
    rf2mb_pkg::t_frame     q_frame;
    rf2mb_pkg::t_q_stat    qs;
    rf2mb_pkg::t_back_stat bs;

    // parser stalls whenever the frame queue is full
    assign i_rx.ready = !qs.full;
    assign take       = i_rx.valid && i_rx.ready;

    rf2mb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_rx.rx_byte),
        .o_push  (push),
        .o_frame (push_frame)
    );

    rf2mb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (push_frame),
        .i_pop   (pop),
        .o_frame (q_frame),
        .o_stat  (qs)
    );

    rf2mb_serial u_serial (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (!qs.empty),
        .i_frame   (q_frame),
        .o_pop     (pop),
        .o_stat    (bs),
        .o_tx      (o_tx)
    );

    // checks
    `RF2MB_ASSERT_NOW(a_push_has_room, push, !qs.full)
    `RF2MB_ASSERT_NEXT(a_pop_starts_frame, pop, bs.busy && (bs.idx == '0))
    `RF2MB_ASSERT_NEXT(a_drain_goes_idle, o_tx.valid && o_tx.ready && o_tx.frame_end && qs.empty, !o_tx.valid)

endmodule
